>>> hw/rtl/wasm_pkg.sv
// ----------------------------------------------------------------------------
// wasm_pkg
// Shared constants, types and character helpers for the word anchored
// substring matcher.
// ----------------------------------------------------------------------------
package wasm_pkg;

   localparam int MAX_QUERY_LEN = 32;
   localparam int LEN_W         = 6;
   localparam int CHAR_W        = 8;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int QUERY_WORDS   = MAX_QUERY_LEN / 8;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_LEN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANCHOR_MODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_WORD0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_WORD1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_WORD2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_WORD3 = 3'd5;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_CASE_DIFF = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_DOT       = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;

   // per-request control from the top level to the cell row
   typedef struct packed {
      logic take;
      logic char_valid;
      logic finish;
   } text_ctrl_type;

   // control broadcast to every cell
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // folds upper-case ascii letters to lower case
   function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CHAR_CASE_DIFF;
      end
      return r;
   endfunction

   // underscore, dot, equals or ascii whitespace
   function automatic logic is_break(input logic [CHAR_W-1:0] c);
      return (c == CHAR_UNDERSCORE) || (c == CHAR_DOT) || (c == CHAR_EQUALS) ||
             (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

>>> hw/rtl/word_anchored_substring_matcher.sv
// ----------------------------------------------------------------------------
// word_anchored_substring_matcher
// Case-insensitive substring search over a byte stream, with optional
// anchoring of a match to the text start or to a break character.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    text_char, char_valid, end_of_text
//   rsp      out        rsp_valid/stall    matched (one per end_of_text)
//   csr      in         csr_valid/ready    csr_index, csr_wdata
//
// One request per clock cycle while req_stall is low; every query position
// is compared in its own cell; the row of 32 cells sets one character a cycle.
// A result shows on rsp the cycle after its final request if none is waiting.
// Reset is synchronous; the block is ready for requests in the first cycle
// after reset, with no clearing pass.
// req_stall rises only when both the output and skid registers hold results.
// ----------------------------------------------------------------------------
module word_anchored_substring_matcher import wasm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_text_char,
   input  logic                  req_char_valid,
   input  logic                  req_end_of_text,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_matched,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LEN_W-1:0]                     query_len_ff;
   logic                                 anchor_mode_ff;
   logic [QUERY_WORDS-1:0][CSR_DATA_W-1:0] query_word_ff;
   logic [MAX_QUERY_LEN-1:0][CHAR_W-1:0] query_chars;
   logic [LEN_W-1:0]                     len_eff;
   logic                                 csr_write;
   logic                                 buf_full;
   logic                                 req_take;
   logic                                 verdict;
   text_ctrl_type                        text_ctrl;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_len_ff   <= '0;
         anchor_mode_ff <= 1'b0;
         query_word_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_QUERY_LEN:   query_len_ff     <= csr_wdata[LEN_W-1:0];
            REG_ANCHOR_MODE: anchor_mode_ff   <= csr_wdata[0];
            REG_QUERY_WORD0: query_word_ff[0] <= csr_wdata;
            REG_QUERY_WORD1: query_word_ff[1] <= csr_wdata;
            REG_QUERY_WORD2: query_word_ff[2] <= csr_wdata;
            REG_QUERY_WORD3: query_word_ff[3] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // oversized lengths act as the full query
   assign len_eff = (query_len_ff > LEN_W'(MAX_QUERY_LEN)) ?
                    LEN_W'(MAX_QUERY_LEN) : query_len_ff;

   // byte i of the query words is query character i
   genvar gq;
   generate
      for (gq = 0; gq < MAX_QUERY_LEN; gq++) begin : g_qchar
         assign query_chars[gq] = query_word_ff[gq / 8][(gq % 8) * CHAR_W +: CHAR_W];
      end
   endgenerate

   // request handshake
   assign req_stall            = buf_full;
   assign req_take             = req_valid && !req_stall;
   assign text_ctrl.take       = req_take;
   assign text_ctrl.char_valid = req_char_valid;
   assign text_ctrl.finish     = req_end_of_text;

   wasm_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (text_ctrl),
      .text_char   (req_text_char),
      .len_eff     (len_eff),
      .anchor_mode (anchor_mode_ff),
      .query_chars (query_chars),
      .matched     (verdict)
   );

   wasm_rsp_buf u_rsp_buf (
      .clock        (clock),
      .reset        (reset),
      .push         (req_take && req_end_of_text),
      .push_matched (verdict),
      .full         (buf_full),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_matched  (rsp_matched)
   );

endmodule

>>> hw/rtl/wasm_cell.sv
// ----------------------------------------------------------------------------
// wasm_cell
// One position of the partial match row: compares the folded text character
// with its query character and passes its partial flag to the next cell.
// ----------------------------------------------------------------------------
module wasm_cell import wasm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [CHAR_W-1:0] text_fold,
   input  logic [CHAR_W-1:0] query_char,
   input  logic              enabled,
   input  logic              last_cell,
   input  logic              enter,
   output logic              part_q,
   output logic              hit
);

   logic part_ff;
   logic part_in;
   logic match;

   // prefix up to this position extends with the current character
   assign match = enabled && enter && (fold_case(query_char) == text_fold);
   assign hit   = ctrl.shift && match && last_cell;

   // next partial flag, cleared at the end of a text
   always_comb begin
      if (ctrl.clear) begin
         part_in = 1'b0;
      end else if (ctrl.shift) begin
         part_in = match;
      end else begin
         part_in = part_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= 1'b0;
      end else begin
         part_ff <= part_in;
      end
   end

   assign part_q = part_ff;

endmodule

>>> hw/rtl/wasm_chain.sv
// ----------------------------------------------------------------------------
// wasm_chain
// Row of match cells plus the per-text state: last character was a break,
// and a full match has been seen. Gives the match verdict for the request
// being taken.
// ----------------------------------------------------------------------------
module wasm_chain import wasm_pkg::*; (
   input  logic                                 clock,
   input  logic                                 reset,
   input  text_ctrl_type                        ctrl,
   input  logic [CHAR_W-1:0]                    text_char,
   input  logic [LEN_W-1:0]                     len_eff,
   input  logic                                 anchor_mode,
   input  logic [MAX_QUERY_LEN-1:0][CHAR_W-1:0] query_chars,
   output logic                                 matched
);

   cell_ctrl_type          cell_ctrl;
   logic [CHAR_W-1:0]      text_fold;
   logic [MAX_QUERY_LEN-1:0] part;
   logic [MAX_QUERY_LEN-1:0] enter;
   logic [MAX_QUERY_LEN-1:0] hit;
   logic                   prev_break_ff;
   logic                   prev_break_in;
   logic                   found_ff;
   logic                   found_in;

   assign cell_ctrl.shift = ctrl.take && ctrl.char_valid;
   assign cell_ctrl.clear = ctrl.take && ctrl.finish;
   assign text_fold       = fold_case(text_char);

   // first cell starts anywhere, or when anchored at text start or after a break
   assign enter[0] = !anchor_mode || prev_break_ff;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_QUERY_LEN; gi++) begin : g_cell
         if (gi > 0) begin : g_link
            assign enter[gi] = part[gi-1];
         end
         wasm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .text_fold  (text_fold),
            .query_char (query_chars[gi]),
            .enabled    (LEN_W'(gi) < len_eff),
            .last_cell  (LEN_W'(gi + 1) == len_eff),
            .enter      (enter[gi]),
            .part_q     (part[gi]),
            .hit        (hit[gi])
         );
      end
   endgenerate

   // per-text state, back to reset values after the final request
   always_comb begin
      prev_break_in = prev_break_ff;
      found_in      = found_ff;
      if (cell_ctrl.clear) begin
         prev_break_in = 1'b1;
         found_in      = 1'b0;
      end else if (cell_ctrl.shift) begin
         prev_break_in = is_break(text_char);
         found_in      = found_ff || (|hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_break_ff <= 1'b1;
         found_ff      <= 1'b0;
      end else begin
         prev_break_ff <= prev_break_in;
         found_ff      <= found_in;
      end
   end

   // verdict includes the character taken with the final request
   assign matched = (len_eff == '0) || found_ff || (cell_ctrl.shift && (|hit));

endmodule

>>> hw/rtl/wasm_rsp_buf.sv
// ----------------------------------------------------------------------------
// wasm_rsp_buf
// Two-entry output buffer: an output register and a skid register, so the
// input side keeps flowing while a result waits to be taken.
// ----------------------------------------------------------------------------
module wasm_rsp_buf import wasm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_matched,
   output logic full,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_matched
);

   logic out_valid_ff;
   logic out_valid_in;
   logic out_matched_ff;
   logic out_matched_in;
   logic skid_valid_ff;
   logic skid_valid_in;
   logic skid_matched_ff;
   logic skid_matched_in;
   logic out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   // refill the output register from the skid first, then from a new push
   always_comb begin
      out_valid_in    = out_valid_ff;
      out_matched_in  = out_matched_ff;
      skid_valid_in   = skid_valid_ff;
      skid_matched_in = skid_matched_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in    = 1'b1;
            out_matched_in  = skid_matched_ff;
            skid_valid_in   = push;
            skid_matched_in = push_matched;
         end else begin
            out_valid_in   = push;
            out_matched_in = push_matched;
         end
      end else if (push) begin
         skid_valid_in   = 1'b1;
         skid_matched_in = push_matched;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_matched_ff  <= out_matched_in;
      skid_matched_ff <= skid_matched_in;
   end

   assign full        = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_matched = out_matched_ff;

endmodule

>>> hw/rtl/wasm_checker.sv
// ----------------------------------------------------------------------------
// wasm_checker
// Port-level checks on the matcher: result ordering against requests, and
// the relation between output backpressure and input stall.
// ----------------------------------------------------------------------------
module wasm_checker import wasm_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_end_of_text,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_matched
);

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_matched))
      else $error("rsp changed while stalled");

   // no result left over from before reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // a final request into an empty output shows up next cycle
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_text && !rsp_valid |=> rsp_valid)
      else $error("result did not appear");

   // a result never appears without a final request
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_end_of_text))
      else $error("result without final request");

   // input stalls only while a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with empty output");

endmodule

bind word_anchored_substring_matcher wasm_checker u_wasm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_end_of_text (req_end_of_text),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_matched     (rsp_matched)
);

>>> dv/word_anchored_substring_matcher_test.sv
// ----------------------------------------------------------------------------
// word_anchored_substring_matcher_test
// Self-checking bench for the substring matcher. Texts are streamed one
// character per request. A predictor of its own tracks the partial-match
// flags and works out the expected result of each finished text, and every
// result is checked in order. Directed texts cover case folding, anchoring,
// empty queries and empty texts, requests without a character, byte
// extremes and oversized lengths. They are followed by a long back-pressure
// stretch and by random queries and texts under three idling patterns.
// ----------------------------------------------------------------------------
module word_anchored_substring_matcher_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wasm_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_CYCLES    = 80;
   localparam int PHASE_REQUESTS = 120;
   localparam int QUERY_BITS     = MAX_QUERY_LEN * CHAR_W;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef logic [CHAR_W-1:0] text_type[$];

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_text_char;
   logic                  req_char_valid;
   logic                  req_end_of_text;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_matched;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor copy of the registers and the per-text state
   logic [LEN_W-1:0]         cfg_len         = '0;
   logic                     cfg_anchor      = 1'b0;
   logic [QUERY_BITS-1:0]    cfg_query       = '0;
   logic [MAX_QUERY_LEN-1:0] run_partial     = '0;
   logic                     run_after_break = 1'b1;
   logic                     run_found       = 1'b0;
   logic                     match_expected[$];
   logic                     want_match;

   int send_idle_pct   = 0;
   int rsp_idle_pct    = 0;
   int hold_left       = 0;
   int requests_sent   = 0;
   int texts_sent      = 0;
   int results_checked = 0;
   int settings_done   = 0;
   int errors          = 0;

   word_anchored_substring_matcher u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_char   (req_text_char),
      .req_char_valid  (req_char_valid),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_matched     (rsp_matched),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("word_anchored_substring_matcher: mismatch");
      $finish;
   end

   // only A-Z fold, onto a-z
   function automatic logic [CHAR_W-1:0] lower_of(input logic [CHAR_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c | 8'h20;
      end
      return c;
   endfunction

   function automatic logic break_char(input logic [CHAR_W-1:0] c);
      return (c == CHAR_UNDERSCORE) || (c == CHAR_DOT) || (c == CHAR_EQUALS) ||
             (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic int active_len();
      return (cfg_len > MAX_QUERY_LEN) ? MAX_QUERY_LEN : int'(cfg_len);
   endfunction

   // advance the partial-match flags by one request, queue a result at text end
   task automatic match_step(input logic [CHAR_W-1:0] ch, input logic cv,
                             input logic eot);
      int                       n;
      int                       i;
      logic                     enter;
      logic [MAX_QUERY_LEN-1:0] nxt;
      n = active_len();
      if (cv) begin
         nxt = '0;
         for (i = 0; i < n; i++) begin
            if (i == 0) begin
               enter = !cfg_anchor || run_after_break;
            end else begin
               enter = run_partial[i-1];
            end
            if (enter && lower_of(cfg_query[i*CHAR_W +: CHAR_W]) == lower_of(ch)) begin
               nxt[i] = 1'b1;
            end
         end
         run_partial = nxt;
         if (n > 0 && nxt[n-1]) begin
            run_found = 1'b1;
         end
         run_after_break = break_char(ch);
      end
      if (eot) begin
         match_expected.push_back((n == 0) || run_found);
         run_partial     = '0;
         run_after_break = 1'b1;
         run_found       = 1'b0;
      end
   endtask

   // request predictor and result checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (match_expected.size() == 0) begin
               errors++;
               $display("%0t: result matched=%0b with no result expected",
                        $time, rsp_matched);
            end else begin
               want_match = match_expected.pop_front();
               results_checked++;
               if (rsp_matched !== want_match) begin
                  errors++;
                  $display("%0t: matched expected %0b actual %0b",
                           $time, want_match, rsp_matched);
               end
            end
         end
         if (req_valid && !req_stall) begin
            match_step(req_text_char, req_char_valid, req_end_of_text);
         end
      end
   end

   // result stall: long hold-off when asked, random otherwise
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic logic [CHAR_W-1:0] pick_break();
      case ($urandom_range(4))
         0:       return CHAR_UNDERSCORE;
         1:       return CHAR_DOT;
         2:       return CHAR_EQUALS;
         3:       return CHAR_SPACE;
         default: return CHAR_W'(CHAR_TAB + $urandom_range(4));
      endcase
   endfunction

   // characters biased towards a few letters so that partial matches overlap
   function automatic logic [CHAR_W-1:0] rand_text_char();
      case ($urandom_range(9))
         0, 1, 2: return CHAR_W'(8'h61 + $urandom_range(2));
         3:       return CHAR_W'(8'h41 + $urandom_range(2));
         4, 5:    return pick_break();
         default: return CHAR_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] random_case(input logic [CHAR_W-1:0] c);
      if (lower_of(c) >= 8'h61 && lower_of(c) <= 8'h7A && $urandom_range(1)) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic text_type from_str(input string s);
      text_type t;
      int       i;
      for (i = 0; i < s.len(); i++) begin
         t.push_back(s[i]);
      end
      return t;
   endfunction

   function automatic logic [QUERY_BITS-1:0] pack_query(input string s);
      logic [QUERY_BITS-1:0] q;
      int                    i;
      q = '0;
      for (i = 0; i < s.len(); i++) begin
         q[i*CHAR_W +: CHAR_W] = s[i];
      end
      return q;
   endfunction

   // one request; the payload holds until it is taken
   task automatic send_item(input logic [CHAR_W-1:0] ch, input logic cv,
                            input logic eot);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid       = 1'b0;
         req_text_char   = CHAR_W'($urandom_range(255));
         req_char_valid  = 1'($urandom_range(1));
         req_end_of_text = 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_text_char   = ch;
      req_char_valid  = cv;
      req_end_of_text = eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cv || eot) requests_sent++;
      if (eot) texts_sent++;
   endtask

   // a whole text; noisy texts get empty requests mixed in and may end on one
   task automatic send_text(input text_type txt, input bit noisy);
      bit marker_end;
      int i;
      marker_end = (txt.size() == 0) || (noisy && $urandom_range(1));
      for (i = 0; i < txt.size(); i++) begin
         if (noisy && $urandom_range(9) == 0) begin
            send_item(CHAR_W'($urandom_range(255)), 1'b0, 1'b0);
         end
         send_item(txt[i], 1'b1, !marker_end && (i == txt.size() - 1));
      end
      if (marker_end) begin
         send_item(CHAR_W'($urandom_range(255)), 1'b0, 1'b1);
      end
   endtask

   // let every result arrive and the last request settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (match_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_QUERY_LEN:   cfg_len = data[LEN_W-1:0];
         REG_ANCHOR_MODE: cfg_anchor = data[0];
         REG_QUERY_WORD0: cfg_query[0*CSR_DATA_W +: CSR_DATA_W] = data;
         REG_QUERY_WORD1: cfg_query[1*CSR_DATA_W +: CSR_DATA_W] = data;
         REG_QUERY_WORD2: cfg_query[2*CSR_DATA_W +: CSR_DATA_W] = data;
         REG_QUERY_WORD3: cfg_query[3*CSR_DATA_W +: CSR_DATA_W] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // new query setting, written only once the block has gone quiet
   task automatic set_query(input logic [CSR_DATA_W-1:0] len_data,
                            input logic [CSR_DATA_W-1:0] anchor_data,
                            input logic [QUERY_BITS-1:0] q);
      wait_idle();
      if ($urandom_range(3) == 0) begin
         write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
      end
      write_reg(REG_QUERY_LEN, len_data);
      write_reg(REG_ANCHOR_MODE, anchor_data);
      write_reg(REG_QUERY_WORD0, q[0*CSR_DATA_W +: CSR_DATA_W]);
      write_reg(REG_QUERY_WORD1, q[1*CSR_DATA_W +: CSR_DATA_W]);
      write_reg(REG_QUERY_WORD2, q[2*CSR_DATA_W +: CSR_DATA_W]);
      write_reg(REG_QUERY_WORD3, q[3*CSR_DATA_W +: CSR_DATA_W]);
      settings_done++;
   endtask

   // mostly short queries, some empty, full length or oversized
   task automatic random_query();
      logic [CSR_DATA_W-1:0] len_data;
      logic [QUERY_BITS-1:0] q;
      int                    pick;
      int                    n;
      int                    i;
      pick = $urandom_range(99);
      if (pick < 8) n = 0;
      else if (pick < 16) n = MAX_QUERY_LEN;
      else if (pick < 24) n = MAX_QUERY_LEN + 1 + $urandom_range(30);
      else n = 1 + $urandom_range(5);
      for (i = 0; i < MAX_QUERY_LEN; i++) begin
         q[i*CHAR_W +: CHAR_W] = rand_text_char();
      end
      len_data = {$urandom, $urandom};
      len_data[LEN_W-1:0] = LEN_W'(n);
      set_query(len_data, {$urandom, $urandom}, q);
   endtask

   // text built round the query: whole, damaged or not at all
   function automatic text_type random_text();
      text_type             t;
      logic [CHAR_W-1:0]    c;
      int                   n;
      int                   kind;
      int                   cut;
      int                   i;
      n    = active_len();
      kind = $urandom_range(9);
      if (kind == 9 && $urandom_range(1)) begin
         return t;
      end
      repeat ($urandom_range(5)) t.push_back(rand_text_char());
      if (cfg_anchor && $urandom_range(2) != 0) begin
         t.push_back(pick_break());
      end
      if (kind < 8 && n > 0) begin
         cut = (kind < 6) ? -1 : $urandom_range(n - 1);
         for (i = 0; i < n; i++) begin
            c = random_case(cfg_query[i*CHAR_W +: CHAR_W]);
            if (i == cut) begin
               if ($urandom_range(1)) break;
               c = c ^ (8'h01 << $urandom_range(7));
            end
            t.push_back(c);
         end
      end else begin
         repeat ($urandom_range(8)) t.push_back(rand_text_char());
      end
      repeat ($urandom_range(3)) t.push_back(rand_text_char());
      return t;
   endfunction

   // reset values: an empty query matches everything
   task automatic test_empty_query();
      send_text(from_str(""), 1'b0);
      send_text(from_str("x"), 1'b0);
   endtask

   // letters fold, bytes above the ascii range do not
   task automatic test_case_folding();
      logic [QUERY_BITS-1:0] q;
      set_query(2, 0, pack_query("aB"));
      send_text(from_str("zAb"), 1'b0);
      q = pack_query("a");
      q[CHAR_W +: CHAR_W] = 8'hC1;
      set_query(2, 0, q);
      send_text('{8'h41, 8'hE1}, 1'b0);
   endtask

   // no character at all matches only the empty query
   task automatic test_empty_text();
      send_text(from_str(""), 1'b0);
   endtask

   // anchored: start of text or after a break only
   task automatic test_anchoring();
      set_query(2, 1, pack_query("ab"));
      send_text(from_str("xab"), 1'b0);
      send_text(from_str("=ab"), 1'b0);
      send_text(from_str("ab"), 1'b0);
   endtask

   // requests without a character leave the flags alone
   task automatic test_charless_requests();
      set_query(2, 0, pack_query("ab"));
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h71, 1'b0, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h78, 1'b0, 1'b1);
   endtask

   task automatic test_byte_extremes();
      set_query(1, 0, {{(QUERY_BITS - CHAR_W){1'b0}}, 8'hFF});
      send_text('{8'h00, 8'hFF}, 1'b0);
   endtask

   // length above the maximum, and writes to unused indexes
   task automatic test_oversized_length();
      set_query({CSR_DATA_W{1'b1}}, 0, {MAX_QUERY_LEN{8'h61}});
      write_reg(REG_SPARE_LO, {CSR_DATA_W{1'b1}});
      write_reg(REG_SPARE_HI, {$urandom, $urandom});
      send_text(from_str("aaa"), 1'b0);
   endtask

   // results held back for a long stretch while requests keep coming
   task automatic test_backpressure();
      int i;
      set_query(1, 0, pack_query("a"));
      send_idle_pct = 0;
      hold_left     = HOLD_CYCLES;
      for (i = 0; i < 24; i++) begin
         send_text(from_str((i % 3 == 0) ? "b" : "A"), 1'b0);
      end
   endtask

   task automatic run_random_phase(input int send_pct, input int rsp_pct);
      int first;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      first         = requests_sent;
      while (requests_sent - first < PHASE_REQUESTS) begin
         random_query();
         repeat ($urandom_range(2, 6)) send_text(random_text(), 1'b1);
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(18, 83);
      run_random_phase(83, 18);
      run_random_phase(0, 0);
   endtask

   // sequence of tests
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_char   = '0;
      req_char_valid  = 1'b0;
      req_end_of_text = 1'b0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      send_idle_pct   = 18;
      rsp_idle_pct    = 83;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_query();
      test_case_folding();
      test_empty_text();
      test_anchoring();
      test_charless_requests();
      test_byte_extremes();
      test_oversized_length();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      $display("ran %0d texts (%0d requests) over %0d query settings,", texts_sent,
               requests_sent, settings_done);
      $display("checked %0d results, %0d errors", results_checked, errors);
      if (errors == 0) begin
         $display("word_anchored_substring_matcher: match");
      end else begin
         $display("word_anchored_substring_matcher: mismatch");
      end
      $finish;
   end

endmodule
